@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker qapd_checker.sv.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define QAPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define QAPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qapd_pkg.sv @@
// Shared widths, register indexes and constants of the quaternion PD torque core.
// No dependencies.
package qapd_pkg;

    localparam int DATA_W    = 16;   // quaternion, rate and torque words
    localparam int GAIN_W    = 16;   // unsigned Q8.8 gains
    localparam int CFG_IDX_W = 1;

    localparam int PROD_W    = 32;   // 16x16 signed product
    localparam int RPROD_W   = 33;   // gain x rate product
    localparam int ERR_W     = 34;   // sum of four products, scale 2^28
    localparam int APROD_W   = 51;   // gain x error, scale 2^36
    localparam int SUM_W     = 52;   // full torque sum, scale 2^36
    localparam int CLAMP_W   = 38;   // clamped torque, scale 2^36
    localparam int OUT_SHIFT = 22;

    localparam logic [CFG_IDX_W-1:0] REG_ATTITUDE_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN     = 1'b1;

    localparam logic signed [SUM_W-1:0]   SAT_HI     = 52'sd68719476736;   // +1.0
    localparam logic signed [SUM_W-1:0]   SAT_LO     = -52'sd68719476736;  // -1.0
    localparam logic signed [CLAMP_W-1:0] ROUND_HALF = 38'sd2097152;

    localparam logic signed [DATA_W-1:0] TORQUE_MAX = 16'sd16384;
    localparam logic signed [DATA_W-1:0] TORQUE_MIN = -16'sd16384;

    typedef logic signed [DATA_W-1:0]  word_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [RPROD_W-1:0] rprod_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [APROD_W-1:0] aprod_t;

endpackage

@@ rtl/quaternion_attitude_pd_torque_core.sv @@
// Quaternion attitude PD torque core: four-stage multiply/accumulate pipeline.
// Depends on qapd_pkg.
//
// One word of setpoint quaternion, measured quaternion and body rates enters per
// cycle while in_ready is high; its torque word passes through four registered
// stages (products, error sums, gain multiply, sum/clamp/round). All stages
// advance together whenever the output register is empty or being taken, so a
// stall on the output freezes the whole pipe, and in_ready equals that advance
// condition. Gains are read live: write them only while no word is in flight.
module quaternion_attitude_pd_torque_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qapd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qapd_pkg::GAIN_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              set_w,
    input  logic signed [15:0]              set_x,
    input  logic signed [15:0]              set_y,
    input  logic signed [15:0]              set_z,
    input  logic signed [15:0]              meas_w,
    input  logic signed [15:0]              meas_x,
    input  logic signed [15:0]              meas_y,
    input  logic signed [15:0]              meas_z,
    input  logic signed [15:0]              rate_roll,
    input  logic signed [15:0]              rate_pitch,
    input  logic signed [15:0]              rate_yaw,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              torque_roll,
    output logic signed [15:0]              torque_pitch,
    output logic signed [15:0]              torque_yaw
);

    logic [qapd_pkg::GAIN_W-1:0] att_gain_reg;
    logic [qapd_pkg::GAIN_W-1:0] rate_gain_reg;

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: quaternion and rate products
    qapd_pkg::prod_t  prod_next [3][4];
    qapd_pkg::prod_t  prod_reg  [3][4];
    qapd_pkg::rprod_t rp1_next  [3];
    qapd_pkg::rprod_t rp1_reg   [3];
    qapd_pkg::word_t  rate_in   [3];

    // stage 2: error vector
    qapd_pkg::err_t   err_next  [3];
    qapd_pkg::err_t   err_reg   [3];
    qapd_pkg::rprod_t rp2_reg   [3];

    // stage 3: attitude term
    qapd_pkg::aprod_t att_next  [3];
    qapd_pkg::aprod_t att_reg   [3];
    qapd_pkg::rprod_t rp3_reg   [3];

    // stage 4: torque
    qapd_pkg::word_t  torque_next [3];
    qapd_pkg::word_t  torque_reg  [3];

    logic signed [qapd_pkg::GAIN_W:0] ka_s;
    logic signed [qapd_pkg::GAIN_W:0] kr_s;

    assign ka_s = {1'b0, att_gain_reg};
    assign kr_s = {1'b0, rate_gain_reg};

    assign advance  = !v4_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_gain_reg  <= '0;
            rate_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qapd_pkg::REG_ATTITUDE_GAIN: att_gain_reg  <= cfg_data;
                qapd_pkg::REG_RATE_GAIN:     rate_gain_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Error vector of S * conj(M): terms ordered so that err = -p0 + p1 + s2*p2 + s3*p3
    always_comb
    begin
        prod_next[0][0] = qapd_pkg::prod_t'(set_w) * qapd_pkg::prod_t'(meas_x);
        prod_next[0][1] = qapd_pkg::prod_t'(set_x) * qapd_pkg::prod_t'(meas_w);
        prod_next[0][2] = qapd_pkg::prod_t'(set_y) * qapd_pkg::prod_t'(meas_z);
        prod_next[0][3] = qapd_pkg::prod_t'(set_z) * qapd_pkg::prod_t'(meas_y);
        prod_next[1][0] = qapd_pkg::prod_t'(set_w) * qapd_pkg::prod_t'(meas_y);
        prod_next[1][1] = qapd_pkg::prod_t'(set_x) * qapd_pkg::prod_t'(meas_z);
        prod_next[1][2] = qapd_pkg::prod_t'(set_y) * qapd_pkg::prod_t'(meas_w);
        prod_next[1][3] = qapd_pkg::prod_t'(set_z) * qapd_pkg::prod_t'(meas_x);
        prod_next[2][0] = qapd_pkg::prod_t'(set_w) * qapd_pkg::prod_t'(meas_z);
        prod_next[2][1] = qapd_pkg::prod_t'(set_x) * qapd_pkg::prod_t'(meas_y);
        prod_next[2][2] = qapd_pkg::prod_t'(set_y) * qapd_pkg::prod_t'(meas_x);
        prod_next[2][3] = qapd_pkg::prod_t'(set_z) * qapd_pkg::prod_t'(meas_w);
        rate_in[0] = rate_roll;
        rate_in[1] = rate_pitch;
        rate_in[2] = rate_yaw;
        for (int a = 0; a < 3; a++)
        begin
            rp1_next[a] = qapd_pkg::rprod_t'(kr_s) * qapd_pkg::rprod_t'(rate_in[a]);
        end
    end

    always_comb
    begin
        err_next[0] = - qapd_pkg::err_t'(prod_reg[0][0]) + qapd_pkg::err_t'(prod_reg[0][1])
                      - qapd_pkg::err_t'(prod_reg[0][2]) + qapd_pkg::err_t'(prod_reg[0][3]);
        err_next[1] = - qapd_pkg::err_t'(prod_reg[1][0]) + qapd_pkg::err_t'(prod_reg[1][1])
                      + qapd_pkg::err_t'(prod_reg[1][2]) - qapd_pkg::err_t'(prod_reg[1][3]);
        err_next[2] = - qapd_pkg::err_t'(prod_reg[2][0]) - qapd_pkg::err_t'(prod_reg[2][1])
                      + qapd_pkg::err_t'(prod_reg[2][2]) + qapd_pkg::err_t'(prod_reg[2][3]);
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            att_next[a] = qapd_pkg::aprod_t'(ka_s) * qapd_pkg::aprod_t'(err_reg[a]);
        end
    end

    // Add attitude and rate terms, negate, clamp to +-1.0, round half up to Q1.14
    always_comb
    begin
        logic signed [qapd_pkg::SUM_W-1:0]   sum;
        logic signed [qapd_pkg::SUM_W-1:0]   t;
        logic signed [qapd_pkg::CLAMP_W-1:0] rnd;
        for (int a = 0; a < 3; a++)
        begin
            sum = qapd_pkg::SUM_W'(att_reg[a])
                + (qapd_pkg::SUM_W'(rp3_reg[a]) <<< 16);
            t = -sum;
            if (t > qapd_pkg::SAT_HI)
                t = qapd_pkg::SAT_HI;
            else if (t < qapd_pkg::SAT_LO)
                t = qapd_pkg::SAT_LO;
            rnd = t[qapd_pkg::CLAMP_W-1:0] + qapd_pkg::ROUND_HALF;
            torque_next[a] = rnd[qapd_pkg::CLAMP_W-1:qapd_pkg::OUT_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            rp1_reg    <= rp1_next;
            err_reg    <= err_next;
            rp2_reg    <= rp1_reg;
            att_reg    <= att_next;
            rp3_reg    <= rp2_reg;
            torque_reg <= torque_next;
        end
    end

    assign out_valid    = v4_reg;
    assign torque_roll  = torque_reg[0];
    assign torque_pitch = torque_reg[1];
    assign torque_yaw   = torque_reg[2];

endmodule

@@ rtl/qapd_checker.sv @@
// Port-level checks for the quaternion PD torque core, bound to its top level.
// Depends on qapd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qapd_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qapd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qapd_pkg::GAIN_W-1:0]     cfg_data,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [15:0]              torque_roll,
    input  logic signed [15:0]              torque_pitch,
    input  logic signed [15:0]              torque_yaw
);

    logic [qapd_pkg::GAIN_W-1:0] ka_reg;
    logic [qapd_pkg::GAIN_W-1:0] kr_reg;
    logic                        gains_zero;
    logic                        out_stall;
    logic [47:0]                 out_word;
    logic                        torque_ok;

    // shadow of the gain registers as seen on the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka_reg <= '0;
            kr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qapd_pkg::REG_ATTITUDE_GAIN: ka_reg <= cfg_data;
                qapd_pkg::REG_RATE_GAIN:     kr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign gains_zero = (ka_reg == '0) && (kr_reg == '0);
    assign out_stall  = out_valid && !out_ready;
    assign out_word   = {torque_yaw, torque_pitch, torque_roll};
    assign torque_ok  = (torque_roll  <= qapd_pkg::TORQUE_MAX)
                     && (torque_roll  >= qapd_pkg::TORQUE_MIN)
                     && (torque_pitch <= qapd_pkg::TORQUE_MAX)
                     && (torque_pitch >= qapd_pkg::TORQUE_MIN)
                     && (torque_yaw   <= qapd_pkg::TORQUE_MAX)
                     && (torque_yaw   >= qapd_pkg::TORQUE_MIN);

    `QAPD_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "output word dropped")
    `QAPD_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_word), "stalled word changed")
    `QAPD_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input blocked with empty output")
    `QAPD_ASSERT(a_range, out_valid |-> torque_ok, "torque beyond +-1.0")
    `QAPD_ASSERT(a_zero_gain, out_valid && gains_zero |-> (out_word == '0), "torque with zero gains")

endmodule

bind quaternion_attitude_pd_torque_core qapd_checker u_qapd_checker (.*);
